// ----- design/lorup_pkg.sv -----
// Shared types, sizes and helper functions for the log-odds ray update unit.
// Used by lorup_line_walker and log_odds_ray_update_unit; depends on nothing.
package lorup_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int VALUE_BITS = 16;

  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COORD_W    = 11;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int ERR_W      = COORD_W + 3;
  localparam int SIZE_W     = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int LIM_W      = ((SIZE_W > 9) ? SIZE_W : 9) + 1;
  localparam int SUM_W      = ((VALUE_BITS > 16) ? VALUE_BITS : 16) + 2;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [SUM_W-1:0] WORD_MAX =
    SUM_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] WORD_MIN = ~WORD_MAX;
  localparam logic signed [SUM_W-1:0] OUT_MAX  = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] OUT_MIN  = ~OUT_MAX;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_HIT_STEP    = 3'd2,
    REG_FREE_STEP   = 3'd3,
    REG_UPPER_LIMIT = 3'd4,
    REG_LOWER_LIMIT = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RAY,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                      valid;
    logic                      hit;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } cell_t;

  function automatic logic cell_inside(input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic [8:0] gw,
                                       input logic [8:0] gh);
    logic [LIM_W-1:0]        w_eff;
    logic [LIM_W-1:0]        h_eff;
    logic signed [LIM_W+COORD_W-1:0] xs;
    logic signed [LIM_W+COORD_W-1:0] ys;
    w_eff = (LIM_W'(gw) > LIM_W'(MAX_WIDTH)) ? LIM_W'(MAX_WIDTH) : LIM_W'(gw);
    h_eff = (LIM_W'(gh) > LIM_W'(MAX_HEIGHT)) ? LIM_W'(MAX_HEIGHT) : LIM_W'(gh);
    xs = (LIM_W+COORD_W)'(x);
    ys = (LIM_W+COORD_W)'(y);
    return !x[COORD_W-1] && !y[COORD_W-1] &&
           (xs < $signed({{COORD_W{1'b0}}, w_eff})) &&
           (ys < $signed({{COORD_W{1'b0}}, h_eff}));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [COORD_W-1:0] x,
                                                  input logic signed [COORD_W-1:0] y);
    logic [ADDR_W-1:0] xa;
    logic [ADDR_W-1:0] ya;
    xa = ADDR_W'(unsigned'(x));
    ya = ADDR_W'(unsigned'(y));
    return ADDR_W'(ya * ADDR_W'(MAX_WIDTH)) + xa;
  endfunction

  function automatic logic signed [SUM_W-1:0] word_sat(input logic signed [SUM_W-1:0] v);
    if (v > WORD_MAX) begin
      return WORD_MAX;
    end else if (v < WORD_MIN) begin
      return WORD_MIN;
    end
    return v;
  endfunction

endpackage

// ----- design/lorup_line_walker.sv -----
// Bresenham line stepper: emits one cell per cycle from start to end, end cell last.
// Depends on lorup_pkg for coordinate widths and the cell_t struct.
module lorup_line_walker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic signed [lorup_pkg::COORD_W-1:0] sx,
  input  logic signed [lorup_pkg::COORD_W-1:0] sy,
  input  logic signed [lorup_pkg::COORD_W-1:0] ex,
  input  logic signed [lorup_pkg::COORD_W-1:0] ey,
  output lorup_pkg::cell_t                    walk_cell
);

  logic                                      active_r, active_nxt;
  logic signed [lorup_pkg::COORD_W-1:0]      x_r, x_nxt, y_r, y_nxt;
  logic signed [lorup_pkg::COORD_W-1:0]      tx_r, ty_r;
  logic signed [lorup_pkg::ERR_W-1:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [lorup_pkg::ERR_W-1:0]        err_r, err_nxt;
  logic                                      stx_r, stx_nxt, sty_r, sty_nxt;
  logic signed [lorup_pkg::DIFF_W-1:0]       ddx, ddy;
  logic signed [lorup_pkg::ERR_W-1:0]        e2;
  logic                                      at_end;

  assign at_end = (x_r == tx_r) && (y_r == ty_r);
  assign e2     = err_r <<< 1;
  assign ddx    = lorup_pkg::DIFF_W'(ex) - lorup_pkg::DIFF_W'(sx);
  assign ddy    = lorup_pkg::DIFF_W'(ey) - lorup_pkg::DIFF_W'(sy);

  always_comb begin
    active_nxt = active_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    stx_nxt    = stx_r;
    sty_nxt    = sty_r;
    err_nxt    = err_r;
    if (load) begin
      active_nxt = 1'b1;
      x_nxt      = sx;
      y_nxt      = sy;
      dx_nxt     = ddx[lorup_pkg::DIFF_W-1] ? -lorup_pkg::ERR_W'(ddx) : lorup_pkg::ERR_W'(ddx);
      dy_nxt     = ddy[lorup_pkg::DIFF_W-1] ? -lorup_pkg::ERR_W'(ddy) : lorup_pkg::ERR_W'(ddy);
      stx_nxt    = (sx < ex);
      sty_nxt    = (sy < ey);
      err_nxt    = dx_nxt - dy_nxt;
    end else if (active_r) begin
      if (at_end) begin
        active_nxt = 1'b0;
      end else begin
        if (e2 > -dy_r) begin
          x_nxt = stx_r ? x_r + 1'b1 : x_r - 1'b1;
        end
        if (e2 < dx_r) begin
          y_nxt = sty_r ? y_r + 1'b1 : y_r - 1'b1;
        end
        err_nxt = err_r - ((e2 > -dy_r) ? dy_r : '0) + ((e2 < dx_r) ? dx_r : '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    stx_r <= stx_nxt;
    sty_r <= sty_nxt;
    err_r <= err_nxt;
    if (load) begin
      tx_r <= ex;
      ty_r <= ey;
    end
  end

  assign walk_cell.valid = active_r;
  assign walk_cell.hit   = at_end;
  assign walk_cell.x     = x_r;
  assign walk_cell.y     = y_r;

endmodule

// ----- design/log_odds_ray_update_unit.sv -----
// Top level of the log-odds occupancy grid: cell store, update datapath and control.
// Depends on lorup_pkg and lorup_line_walker.
//
//   channel  handshake             payload
//   in_      start / busy          in_operation, in_start_x/y, in_end_x/y
//   out_     out_valid (strobe)    out_cell_value, out_cell_outside
//   cfg_     cfg_valid / cfg_ready cfg_index, cfg_data
//
// After reset all 65536 store words are swept to zero, one word a cycle, with busy high.
// An insert beat keeps busy high through the ray walk and the drain state: one store word is
// read, updated and written back per cycle along the line through the single store.
// A read beat passes through the read and response states; its result strobes in the response state.
// The receiver cannot stall; configuration beats are always ready.
module log_odds_ray_update_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_operation,
  input  logic signed [lorup_pkg::COORD_W-1:0]   in_start_x,
  input  logic signed [lorup_pkg::COORD_W-1:0]   in_start_y,
  input  logic signed [lorup_pkg::COORD_W-1:0]   in_end_x,
  input  logic signed [lorup_pkg::COORD_W-1:0]   in_end_y,
  output logic                                   out_valid,
  output logic signed [lorup_pkg::OUT_W-1:0]     out_cell_value,
  output logic                                   out_cell_outside,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lorup_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lorup_pkg::CFG_DATA_W-1:0]       cfg_data
);

  lorup_pkg::state_t                         state_r, state_nxt;
  logic [8:0]                                grid_width_r, grid_height_r;
  logic [14:0]                               hit_step_r;
  logic signed [15:0]                        free_step_r, upper_limit_r, lower_limit_r;
  logic [lorup_pkg::ADDR_W-1:0]              clear_addr_r, clear_addr_nxt;
  logic signed [lorup_pkg::COORD_W-1:0]      rd_x_r, rd_y_r;
  logic                                      outside_r;
  logic                                      p1_valid_r, p1_hit_r;
  logic [lorup_pkg::ADDR_W-1:0]              p1_addr_r;
  logic signed [lorup_pkg::VALUE_BITS-1:0]   store_mem_r [lorup_pkg::CELL_COUNT];
  logic signed [lorup_pkg::VALUE_BITS-1:0]   rd_data_r;

  lorup_pkg::cell_t                          walk_cell;
  logic                                      accept, walk_load, clear_last, read_cycle;
  logic                                      cell_in;
  logic [lorup_pkg::ADDR_W-1:0]              rd_addr, wr_addr;
  logic                                      wr_en;
  logic signed [lorup_pkg::VALUE_BITS-1:0]   wr_data;
  logic signed [lorup_pkg::SUM_W-1:0]        old_word, free_sum, hit_sum, new_word;
  logic signed [lorup_pkg::SUM_W-1:0]        rd_ext;

  assign accept     = start && !busy;
  assign clear_last = (clear_addr_r == lorup_pkg::ADDR_W'(lorup_pkg::CELL_COUNT - 1));
  assign cfg_ready  = 1'b1;

  lorup_line_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (walk_load),
    .sx        (in_start_x),
    .sy        (in_start_y),
    .ex        (in_end_x),
    .ey        (in_end_y),
    .walk_cell (walk_cell)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lorup_pkg::ST_CLEAR: begin
        if (clear_last) begin
          state_nxt = lorup_pkg::ST_IDLE;
        end
      end
      lorup_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_operation == lorup_pkg::OP_READ) ? lorup_pkg::ST_READ
                                                            : lorup_pkg::ST_RAY;
        end
      end
      lorup_pkg::ST_RAY: begin
        if (walk_cell.valid && walk_cell.hit) begin
          state_nxt = lorup_pkg::ST_DRAIN;
        end
      end
      lorup_pkg::ST_DRAIN: state_nxt = lorup_pkg::ST_IDLE;
      lorup_pkg::ST_READ:  state_nxt = lorup_pkg::ST_RESP;
      lorup_pkg::ST_RESP:  state_nxt = lorup_pkg::ST_IDLE;
      default:             state_nxt = lorup_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_r != lorup_pkg::ST_IDLE);
    walk_load  = accept && (in_operation == lorup_pkg::OP_INSERT);
    read_cycle = (state_r == lorup_pkg::ST_READ);
    out_valid  = (state_r == lorup_pkg::ST_RESP);
  end

  always_comb begin
    clear_addr_nxt = clear_addr_r;
    if (state_r == lorup_pkg::ST_CLEAR) begin
      clear_addr_nxt = clear_addr_r + 1'b1;
    end
  end

  assign cell_in = lorup_pkg::cell_inside(walk_cell.x, walk_cell.y, grid_width_r,
                                          grid_height_r);
  assign rd_addr = read_cycle ? lorup_pkg::cell_addr(rd_x_r, rd_y_r)
                              : lorup_pkg::cell_addr(walk_cell.x, walk_cell.y);

  always_comb begin
    old_word = lorup_pkg::SUM_W'(rd_data_r);
    free_sum = old_word + lorup_pkg::SUM_W'(free_step_r);
    if (free_sum < lorup_pkg::SUM_W'(lower_limit_r)) begin
      free_sum = lorup_pkg::SUM_W'(lower_limit_r);
    end
    hit_sum = old_word + $signed({{(lorup_pkg::SUM_W-15){1'b0}}, hit_step_r});
    if (hit_sum > lorup_pkg::SUM_W'(upper_limit_r)) begin
      hit_sum = lorup_pkg::SUM_W'(upper_limit_r);
    end
    new_word = lorup_pkg::word_sat(p1_hit_r ? hit_sum : free_sum);
  end

  always_comb begin
    if (state_r == lorup_pkg::ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clear_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = p1_valid_r;
      wr_addr = p1_addr_r;
      wr_data = lorup_pkg::VALUE_BITS'(new_word);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= store_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lorup_pkg::ST_CLEAR;
      clear_addr_r  <= '0;
      p1_valid_r    <= 1'b0;
      grid_width_r  <= 9'd256;
      grid_height_r <= 9'd256;
      hit_step_r    <= 15'd218;
      free_step_r   <= -16'sd102;
      upper_limit_r <= 16'sd896;
      lower_limit_r <= -16'sd512;
    end else begin
      state_r      <= state_nxt;
      clear_addr_r <= clear_addr_nxt;
      p1_valid_r   <= (state_r == lorup_pkg::ST_RAY) && walk_cell.valid && cell_in;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lorup_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data[8:0];
          lorup_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data[8:0];
          lorup_pkg::REG_HIT_STEP:    hit_step_r    <= cfg_data[14:0];
          lorup_pkg::REG_FREE_STEP:   free_step_r   <= $signed(cfg_data);
          lorup_pkg::REG_UPPER_LIMIT: upper_limit_r <= $signed(cfg_data);
          lorup_pkg::REG_LOWER_LIMIT: lower_limit_r <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_hit_r  <= walk_cell.hit;
    p1_addr_r <= rd_addr;
    if (accept) begin
      rd_x_r <= in_end_x;
      rd_y_r <= in_end_y;
    end
    if (read_cycle) begin
      outside_r <= !lorup_pkg::cell_inside(rd_x_r, rd_y_r, grid_width_r, grid_height_r);
    end
  end

  assign rd_ext = lorup_pkg::SUM_W'(rd_data_r);

  always_comb begin
    if (outside_r) begin
      out_cell_value = '0;
    end else if (rd_ext > lorup_pkg::OUT_MAX) begin
      out_cell_value = lorup_pkg::OUT_W'(lorup_pkg::OUT_MAX);
    end else if (rd_ext < lorup_pkg::OUT_MIN) begin
      out_cell_value = lorup_pkg::OUT_W'(lorup_pkg::OUT_MIN);
    end else begin
      out_cell_value = lorup_pkg::OUT_W'(rd_ext);
    end
    out_cell_outside = outside_r;
  end

endmodule

// ----- dv/lorup_grid_checker.sv -----
// Checker for log_odds_ray_update_unit: keeps a mirror of the log-odds grid, predicts every
// read beat and compares it with the result strobe. Depends on lorup_pkg only.
module lorup_grid_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic                                 in_operation,
  input  logic signed [lorup_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [lorup_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [lorup_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [lorup_pkg::COORD_W-1:0] in_end_y,
  input  logic                                 out_valid,
  input  logic signed [lorup_pkg::OUT_W-1:0]   out_cell_value,
  input  logic                                 out_cell_outside,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [lorup_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lorup_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                   fail_count,
  output int                                   pending_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_LO = -(1 <<< (lorup_pkg::VALUE_BITS - 1));
  localparam int WORD_HI = (1 <<< (lorup_pkg::VALUE_BITS - 1)) - 1;

  typedef struct {
    logic signed [lorup_pkg::OUT_W-1:0] value;
    logic                               outside;
    int                                 x;
    int                                 y;
  } cell_read_t;

  logic signed [lorup_pkg::VALUE_BITS-1:0] grid_mirror [lorup_pkg::CELL_COUNT];
  cell_read_t                              expected_reads [$];
  int width_reg;
  int height_reg;
  int hit_reg;
  int free_reg;
  int upper_reg;
  int lower_reg;

  function automatic int saturate(input int v, input int lo, input int hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic bit on_grid(input int x, input int y);
    int w;
    int h;
    w = (width_reg > lorup_pkg::MAX_WIDTH) ? lorup_pkg::MAX_WIDTH : width_reg;
    h = (height_reg > lorup_pkg::MAX_HEIGHT) ? lorup_pkg::MAX_HEIGHT : height_reg;
    return x >= 0 && x < w && y >= 0 && y < h;
  endfunction

  function automatic void add_free(input int x, input int y);
    int a;
    int v;
    if (!on_grid(x, y)) begin
      return;
    end
    a = y * lorup_pkg::MAX_WIDTH + x;
    v = int'(grid_mirror[a]) + free_reg;
    if (v < lower_reg) begin
      v = lower_reg;
    end
    grid_mirror[a] = lorup_pkg::VALUE_BITS'(saturate(v, WORD_LO, WORD_HI));
  endfunction

  function automatic void add_hit(input int x, input int y);
    int a;
    int v;
    if (!on_grid(x, y)) begin
      return;
    end
    a = y * lorup_pkg::MAX_WIDTH + x;
    v = int'(grid_mirror[a]) + hit_reg;
    if (v > upper_reg) begin
      v = upper_reg;
    end
    grid_mirror[a] = lorup_pkg::VALUE_BITS'(saturate(v, WORD_LO, WORD_HI));
  endfunction

  // Bresenham walk: every cell before the end cell takes the free update.
  function automatic void insert_ray(input int x, input int y, input int tx, input int ty);
    int dx;
    int dy;
    int stx;
    int sty;
    int err;
    int e2;
    dx  = (tx > x) ? tx - x : x - tx;
    dy  = (ty > y) ? ty - y : y - ty;
    stx = (x < tx) ? 1 : -1;
    sty = (y < ty) ? 1 : -1;
    err = dx - dy;
    while (!(x == tx && y == ty)) begin
      e2 = 2 * err;
      add_free(x, y);
      if (e2 > -dy) begin
        err -= dy;
        x += stx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sty;
      end
    end
    add_hit(tx, ty);
  endfunction

  function automatic cell_read_t read_cell(input int x, input int y);
    cell_read_t r;
    r.x = x;
    r.y = y;
    if (on_grid(x, y)) begin
      r.value   = lorup_pkg::OUT_W'(saturate(int'(grid_mirror[y * lorup_pkg::MAX_WIDTH + x]),
                                             -32768, 32767));
      r.outside = 1'b0;
    end else begin
      r.value   = '0;
      r.outside = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cell_read_t exp_read;
    if (!rst_n) begin
      width_reg  = 256;
      height_reg = 256;
      hit_reg    = 218;
      free_reg   = -102;
      upper_reg  = 896;
      lower_reg  = -512;
      expected_reads.delete();
      fail_count = 0;
      for (int a = 0; a < lorup_pkg::CELL_COUNT; a++) begin
        grid_mirror[a] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (lorup_pkg::cfg_reg_t'(cfg_index))
          lorup_pkg::REG_GRID_WIDTH:  width_reg = int'(cfg_data[8:0]);
          lorup_pkg::REG_GRID_HEIGHT: height_reg = int'(cfg_data[8:0]);
          lorup_pkg::REG_HIT_STEP:    hit_reg = int'(cfg_data[14:0]);
          lorup_pkg::REG_FREE_STEP:   free_reg = int'($signed(cfg_data));
          lorup_pkg::REG_UPPER_LIMIT: upper_reg = int'($signed(cfg_data));
          lorup_pkg::REG_LOWER_LIMIT: lower_reg = int'($signed(cfg_data));
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (lorup_pkg::op_t'(in_operation) == lorup_pkg::OP_INSERT) begin
          insert_ray(int'(in_start_x), int'(in_start_y), int'(in_end_x), int'(in_end_y));
        end else begin
          expected_reads = {expected_reads, read_cell(int'(in_end_x), int'(in_end_y))};
        end
      end
      if (out_valid) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual value %0d outside %0b",
                   $time, out_cell_value, out_cell_outside);
          fail_count++;
        end else begin
          exp_read = expected_reads.pop_front();
          if (out_cell_value !== exp_read.value) begin
            $display("%0t: cell_value of (%0d,%0d): expected %0d, actual %0d",
                     $time, exp_read.x, exp_read.y, exp_read.value, out_cell_value);
            fail_count++;
          end
          if (out_cell_outside !== exp_read.outside) begin
            $display("%0t: cell_outside of (%0d,%0d): expected %0b, actual %0b",
                     $time, exp_read.x, exp_read.y, exp_read.outside, out_cell_outside);
            fail_count++;
          end
        end
      end
    end
    pending_reads = expected_reads.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Top of the log_odds_ray_update_unit testbench: clock, reset, ray and read stimulus,
// register settings and the verdict. Depends on lorup_pkg and lorup_grid_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 12_000_000;
  localparam int SETTLE_CYCLES = 2200;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic                                 in_operation;
  logic signed [lorup_pkg::COORD_W-1:0] in_start_x;
  logic signed [lorup_pkg::COORD_W-1:0] in_start_y;
  logic signed [lorup_pkg::COORD_W-1:0] in_end_x;
  logic signed [lorup_pkg::COORD_W-1:0] in_end_y;
  logic                                 out_valid;
  logic signed [lorup_pkg::OUT_W-1:0]   out_cell_value;
  logic                                 out_cell_outside;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [lorup_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [lorup_pkg::CFG_DATA_W-1:0]     cfg_data;
  int                                   fail_count;
  int                                   pending_reads;
  int                                   cycle_count = 0;

  bit no_gaps;
  int span;
  int hot_x [8];
  int hot_y [8];
  int ray_src_x [4];
  int ray_src_y [4];

  log_odds_ray_update_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .out_valid       (out_valid),
    .out_cell_value  (out_cell_value),
    .out_cell_outside(out_cell_outside),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  lorup_grid_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .out_valid       (out_valid),
    .out_cell_value  (out_cell_value),
    .out_cell_outside(out_cell_outside),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_reads   (pending_reads)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic send_beat(input lorup_pkg::op_t op, input int sx, input int sy, input int ex,
                           input int ey);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_start_x   <= lorup_pkg::COORD_W'(sx);
    in_start_y   <= lorup_pkg::COORD_W'(sy);
    in_end_x     <= lorup_pkg::COORD_W'(ex);
    in_end_y     <= lorup_pkg::COORD_W'(ey);
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_reads != 0) @(negedge clk);
  endtask

  task automatic write_reg(input lorup_pkg::cfg_reg_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= lorup_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Rays concentrate on a few origins and end cells so that words reach the limits.
  task automatic aim_targets(input int w, input int h);
    int sw;
    int sh;
    sw = (w > lorup_pkg::MAX_WIDTH) ? lorup_pkg::MAX_WIDTH : w;
    sh = (h > lorup_pkg::MAX_HEIGHT) ? lorup_pkg::MAX_HEIGHT : h;
    sw = (sw == 0) ? 16 : sw;
    sh = (sh == 0) ? 16 : sh;
    span = (sw > sh) ? sw : sh;
    foreach (hot_x[i]) begin
      hot_x[i] = pick(0, sw - 1);
      hot_y[i] = pick(0, sh - 1);
    end
    foreach (ray_src_x[i]) begin
      ray_src_x[i] = pick(0, sw - 1);
      ray_src_y[i] = pick(0, sh - 1);
    end
  endtask

  task automatic apply_setting(input int w, input int h, input int hit, input int free,
                               input int upper, input int lower);
    go_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(lorup_pkg::REG_GRID_WIDTH, w);
    write_reg(lorup_pkg::REG_GRID_HEIGHT, h);
    write_reg(lorup_pkg::REG_HIT_STEP, hit);
    write_reg(lorup_pkg::REG_FREE_STEP, free);
    write_reg(lorup_pkg::REG_UPPER_LIMIT, upper);
    write_reg(lorup_pkg::REG_LOWER_LIMIT, lower);
    cfg_valid <= 1'b0;
    aim_targets(w, h);
  endtask

  task automatic run_mixed_traffic(input int count);
    int r;
    int k;
    int sx;
    int sy;
    int ex;
    int ey;
    for (int n = 0; n < count; n++) begin
      if (n % 48 == 0) begin
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      if (n % 97 == 96) begin
        go_idle();
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_beat(lorup_pkg::OP_INSERT, pick(-1024, 1023), pick(-1024, 1023),
                  pick(-1024, 1023), pick(-1024, 1023));
      end else if (r < 58) begin
        k = $urandom_range(0, 3);
        sx = $urandom_range(0, 1) ? ray_src_x[k] : pick(-12, span + 11);
        sy = $urandom_range(0, 1) ? ray_src_y[k] : pick(-12, span + 11);
        k = $urandom_range(0, 7);
        if ($urandom_range(0, 1)) begin
          ex = hot_x[k];
          ey = hot_y[k];
        end else begin
          ex = pick(-12, span + 11);
          ey = pick(-12, span + 11);
        end
        send_beat(lorup_pkg::OP_INSERT, sx, sy, ex, ey);
      end else if (r < 66) begin
        send_beat(lorup_pkg::OP_READ, pick(-1024, 1023), pick(-1024, 1023),
                  pick(-1024, 1023), pick(-1024, 1023));
      end else begin
        k = $urandom_range(0, 7);
        if ($urandom_range(0, 1)) begin
          ex = hot_x[k];
          ey = hot_y[k];
        end else begin
          ex = pick(-4, span + 3);
          ey = pick(-4, span + 3);
        end
        send_beat(lorup_pkg::OP_READ, pick(-1024, 1023), pick(-1024, 1023), ex, ey);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = 1'b0;
    in_start_x   = '0;
    in_start_y   = '0;
    in_end_x     = '0;
    in_end_y     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    no_gaps      = 1'b0;
    aim_targets(256, 256);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_beat(lorup_pkg::OP_READ, 0, 0, 0, 0);
    send_beat(lorup_pkg::OP_INSERT, 5, 5, 5, 5);
    send_beat(lorup_pkg::OP_READ, 0, 0, 5, 5);
    send_beat(lorup_pkg::OP_INSERT, 0, 0, 10, 3);
    send_beat(lorup_pkg::OP_READ, 0, 0, 10, 3);
    repeat (5) send_beat(lorup_pkg::OP_INSERT, 7, 7, 7, 7);
    send_beat(lorup_pkg::OP_READ, 0, 0, 7, 7);
    repeat (6) send_beat(lorup_pkg::OP_INSERT, 20, 20, 20, 30);
    send_beat(lorup_pkg::OP_READ, 0, 0, 20, 22);
    send_beat(lorup_pkg::OP_INSERT, -1024, -1024, 1023, 1023);
    send_beat(lorup_pkg::OP_INSERT, 1023, -1024, -1024, 1023);
    send_beat(lorup_pkg::OP_INSERT, 50, 50, 45, 60);
    send_beat(lorup_pkg::OP_INSERT, 50, 50, 60, 45);
    send_beat(lorup_pkg::OP_READ, 0, 0, -1, 0);
    send_beat(lorup_pkg::OP_READ, 0, 0, 255, 255);
    send_beat(lorup_pkg::OP_READ, -1024, -1024, 1023, 1023);
    send_beat(lorup_pkg::OP_READ, 1023, 1023, -1024, -1024);
    run_mixed_traffic(400);

    apply_setting(100, 60, 1000, -300, 2000, -1500);
    run_mixed_traffic(200);
    apply_setting(511, 0, 218, -102, 896, -512);
    run_mixed_traffic(60);
    apply_setting(1, 1, 32767, -32768, 32767, -32768);
    run_mixed_traffic(120);
    apply_setting(256, 256, 0, 0, -1000, 1000);
    run_mixed_traffic(150);
    apply_setting(256, 256, 218, -102, 896, -512);
    run_mixed_traffic(180);
    apply_setting(300, 17, 5000, -7000, 20000, -20000);
    run_mixed_traffic(100);
    apply_setting($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 32767),
                  -int'($urandom_range(0, 32768)), pick(-32768, 32767), pick(-32768, 32767));
    run_mixed_traffic(120);

    go_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
